>>> hw/rtl/stef_pkg.sv
// ----------------------------------------------------------------------------
// stef_pkg
// Types and constants shared by the edge trigger finder files.
// ----------------------------------------------------------------------------
package stef_pkg;

   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned OUTCOME_W  = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] LEVEL_RESET  = 8'd128;
   localparam logic [POS_W-1:0]    OFFSET_RESET = 16'd0;
   localparam logic [POS_W-1:0]    LENGTH_RESET = 16'd4096;
   localparam logic [POS_W-1:0]    SCREEN_RESET = 16'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIGGER_LEVEL = 2'd0,
      CSR_START_OFFSET  = 2'd1,
      CSR_RECORD_LENGTH = 2'd2,
      CSR_SCREEN_WIDTH  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_SEEK_LOW   = 2'd0,
      PHASE_SEEK_HIGH  = 2'd1,
      PHASE_SEEK_AGAIN = 2'd2
   } phase_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_FULL_EDGE   = 2'd0,
      OUTCOME_FIRST_CROSS = 2'd1,
      OUTCOME_OFFSET      = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] trigger_level;
      logic [POS_W-1:0]    start_offset;
      logic [POS_W-1:0]    record_length;
      logic [POS_W-1:0]    screen_width;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] trigger_position;
      outcome_type      outcome;
   } result_type;

endpackage

>>> hw/rtl/stef_req_if.sv
// ----------------------------------------------------------------------------
// stef_req_if
// Sample channel: valid/ready handshake carrying one record sample a beat.
// ----------------------------------------------------------------------------
interface stef_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

>>> hw/rtl/stef_rsp_if.sv
// ----------------------------------------------------------------------------
// stef_rsp_if
// Result channel: valid/ready handshake carrying one trigger result a beat.
// ----------------------------------------------------------------------------
interface stef_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] trigger_position;
   logic [1:0]  outcome;

   modport source (output valid, output trigger_position, output outcome, input ready);
   modport sink   (input valid, input trigger_position, input outcome, output ready);
endinterface

>>> hw/rtl/stef_csr.sv
// ----------------------------------------------------------------------------
// stef_csr
// Configuration registers: level, start offset, record length, screen width.
// ----------------------------------------------------------------------------
module stef_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [stef_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stef_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output stef_pkg::cfg_type                    cfg
);
   import stef_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIGGER_LEVEL: cfg_in.trigger_level = csr_wdata[SAMPLE_W-1:0];
            CSR_START_OFFSET:  cfg_in.start_offset  = csr_wdata[POS_W-1:0];
            CSR_RECORD_LENGTH: cfg_in.record_length = csr_wdata[POS_W-1:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[POS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level <= LEVEL_RESET;
         cfg_ff.start_offset  <= OFFSET_RESET;
         cfg_ff.record_length <= LENGTH_RESET;
         cfg_ff.screen_width  <= SCREEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/stef_search.sv
// ----------------------------------------------------------------------------
// stef_search
// Input register and crossing search; decides one result per record.
// ----------------------------------------------------------------------------
module stef_search (
   input  logic                 clock,
   input  logic                 reset,
   stef_req_if.sink             req,
   input  stef_pkg::cfg_type    cfg,
   input  logic                 res_free,
   output logic                 res_load,
   output stef_pkg::result_type res_data
);
   import stef_pkg::*;

   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_last_ff;

   phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]    index_ff, index_in;
   logic [POS_W-1:0]    first_cross_ff, first_cross_in;
   logic                sent_ff, sent_in;

   logic [POS_W-1:0]    half;
   logic [POS_W-1:0]    limit;
   logic                in_window;
   logic                asserted;
   logic                edge_hit;
   logic                emit;
   logic                advance;

   assign half      = cfg.screen_width >> 1;
   assign limit     = cfg.record_length - half;
   assign asserted  = (s1_sample_ff <= cfg.trigger_level);
   assign in_window = !sent_ff && (index_ff >= cfg.start_offset) && (index_ff <= limit);

   always_comb begin
      phase_in       = phase_ff;
      first_cross_in = first_cross_ff;
      edge_hit       = 1'b0;
      if (in_window) begin
         unique case (phase_ff)
            PHASE_SEEK_HIGH: begin
               if (!asserted) phase_in = PHASE_SEEK_AGAIN;
            end
            PHASE_SEEK_AGAIN: begin
               if (asserted) edge_hit = 1'b1;
            end
            default: begin
               if (asserted) begin
                  first_cross_in = index_ff;
                  phase_in       = PHASE_SEEK_HIGH;
               end
            end
         endcase
      end

      // Result: full edge now, or the fallback on the record's last sample.
      emit = edge_hit || (s1_last_ff && !sent_ff);
      if (edge_hit) begin
         res_data.trigger_position = index_ff - half;
         res_data.outcome          = OUTCOME_FULL_EDGE;
      end else if (phase_in == PHASE_SEEK_HIGH) begin
         res_data.trigger_position = first_cross_in - half;
         res_data.outcome          = OUTCOME_FIRST_CROSS;
      end else begin
         res_data.trigger_position = cfg.start_offset;
         res_data.outcome          = OUTCOME_OFFSET;
      end

      sent_in  = sent_ff || edge_hit;
      index_in = index_ff + 1'b1;
      if (s1_last_ff) begin
         phase_in       = PHASE_SEEK_LOW;
         index_in       = '0;
         first_cross_in = '0;
         sent_in        = 1'b0;
      end
   end

   // Hold the sample only while its result cannot be placed.
   assign advance   = s1_valid_ff && (!emit || res_free);
   assign res_load  = advance && emit;
   assign req.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         phase_ff       <= PHASE_SEEK_LOW;
         index_ff       <= '0;
         first_cross_ff <= '0;
         sent_ff        <= 1'b0;
      end else begin
         if (req.ready) s1_valid_ff <= req.valid;
         if (advance) begin
            phase_ff       <= phase_in;
            index_ff       <= index_in;
            first_cross_ff <= first_cross_in;
            sent_ff        <= sent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_sample_ff <= req.sample;
         s1_last_ff   <= req.last_sample;
      end
   end

endmodule

>>> hw/rtl/stef_out_reg.sv
// ----------------------------------------------------------------------------
// stef_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module stef_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_load,
   input  stef_pkg::result_type res_data,
   output logic                 res_free,
   stef_rsp_if.source           rsp
);
   import stef_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign res_free = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_free) begin
         valid_ff <= res_load;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load && res_free) begin
         data_ff <= res_data;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.trigger_position = data_ff.trigger_position;
   assign rsp.outcome          = data_ff.outcome;

endmodule

>>> hw/rtl/scope_edge_trigger_finder.sv
// ----------------------------------------------------------------------------
// scope_edge_trigger_finder
// Finds the display start of a captured record from a falling-rising-falling
// crossing pattern around the trigger level.
// ----------------------------------------------------------------------------
// Feed the record one sample a beat on req_bus, marking the final sample with
// last_sample. The block accepts one sample every clock unless it stalls. A
// sample goes into an input register on its beat, and its result goes from
// there into the result register, which drives rsp_bus. The search logic
// sits between the two registers. The sample channel stalls only when a
// sample would produce a result while the result register still holds one
// that has not been taken. Each record gives exactly one result beat: on the
// sample completing a full edge (outcome 0), or else on the last sample
// (outcome 1, first crossing minus half the screen, when the rise never came;
// outcome 2, the start offset, when nothing crossed or the final fall never
// came). Samples before start_offset or beyond record_length minus half the
// screen are ignored. Write the csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
module scope_edge_trigger_finder (
   input  logic                            clock,
   input  logic                            reset,
   stef_req_if.sink                        req_bus,
   stef_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [stef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stef_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import stef_pkg::*;

   cfg_type    cfg;
   logic       res_free;
   logic       res_load;
   result_type res_data;

   // Hold the configuration registers.
   stef_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Register each sample, advance the crossing search, decide the result.
   stef_search u_search (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .cfg      (cfg),
      .res_free (res_free),
      .res_load (res_load),
      .res_data (res_data)
   );

   // Hold the result until the sink takes the beat.
   stef_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .res_load (res_load),
      .res_data (res_data),
      .res_free (res_free),
      .rsp      (rsp_bus)
   );

endmodule

>>> hw/rtl/stef_checker.sv
// ----------------------------------------------------------------------------
// stef_checker
// Port-level checks for the edge trigger finder, bound to the top level.
// ----------------------------------------------------------------------------
module stef_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_trigger_position,
   input logic [1:0]  rsp_outcome
);
   import stef_pkg::*;

   // A result register fed only by the search stage: a new result shows up only
   // after the beat of the sample that caused it, through the input register.
   a_result_follows_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a sample beat two edges earlier");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == OUTCOME_FULL_EDGE ||
                     rsp_outcome == OUTCOME_FIRST_CROSS ||
                     rsp_outcome == OUTCOME_OFFSET))
      else $error("result outcome outside the defined codes");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready) |->
         (rsp_valid && $stable(rsp_trigger_position) && $stable(rsp_outcome)))
      else $error("stalled result beat changed");

endmodule

bind scope_edge_trigger_finder stef_checker u_stef_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_trigger_position (rsp_bus.trigger_position),
   .rsp_outcome          (rsp_bus.outcome)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge trigger finder. Records of samples are
// fed over the sample channel and every trigger result is compared with a
// hand-written value or with a behavioural copy of the search kept inside
// the bench. A short table of hand-written records comes first, then
// random records under changing register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import stef_pkg::*;

   // Kinds of row in the directed table
   typedef enum bit {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type        kind;
      csr_index_type       reg_idx;
      logic [POS_W-1:0]    wdata;
      logic [SAMPLE_W-1:0] sample;
      logic                is_last;
      bit                  typed;
      result_type          want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   stef_req_if req_bus ();
   stef_rsp_if rsp_bus ();

   scope_edge_trigger_finder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Bench copy of the registers, starting from their reset values
   logic [SAMPLE_W-1:0] lvl_q    = LEVEL_RESET;
   logic [POS_W-1:0]    offset_q = OFFSET_RESET;
   logic [POS_W-1:0]    length_q = LENGTH_RESET;
   logic [POS_W-1:0]    screen_q = SCREEN_RESET;

   // Bench copy of the search state
   phase_type        hunt_phase  = PHASE_SEEK_LOW;
   logic [POS_W-1:0] next_index  = '0;
   logic [POS_W-1:0] cross_index = '0;
   bit               record_done = 1'b0;

   // Trigger results still owed by the block, oldest first
   result_type trigger_q[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sample_count = 0;
   int record_count = 0;
   int result_count = 0;
   int config_count = 0;
   int mismatch_count = 0;

   dir_row_type plan[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advance the search by one sample; return whether it yields a trigger result
   task automatic predict_trigger(input logic [SAMPLE_W-1:0] s, input logic is_last,
                                  output bit fires, output result_type r);
      logic [POS_W-1:0] half;
      logic [POS_W-1:0] limit;
      logic [POS_W-1:0] cur;
      bit               low;
      half  = screen_q >> 1;
      limit = length_q - half;
      cur   = next_index;
      low   = (s <= lvl_q);
      fires = 1'b0;
      r     = '0;
      if (!record_done && cur >= offset_q && cur <= limit) begin
         case (hunt_phase)
            PHASE_SEEK_HIGH: begin
               if (!low) hunt_phase = PHASE_SEEK_AGAIN;
            end
            PHASE_SEEK_AGAIN: begin
               if (low) begin
                  r.trigger_position = cur - half;
                  r.outcome          = OUTCOME_FULL_EDGE;
                  record_done        = 1'b1;
                  fires              = 1'b1;
               end
            end
            default: begin
               if (low) begin
                  cross_index = cur;
                  hunt_phase  = PHASE_SEEK_HIGH;
               end
            end
         endcase
      end
      if (is_last) begin
         if (!record_done) begin
            if (hunt_phase == PHASE_SEEK_HIGH) begin
               r.trigger_position = cross_index - half;
               r.outcome          = OUTCOME_FIRST_CROSS;
            end else begin
               r.trigger_position = offset_q;
               r.outcome          = OUTCOME_OFFSET;
            end
            fires = 1'b1;
         end
         hunt_phase  = PHASE_SEEK_LOW;
         next_index  = '0;
         cross_index = '0;
         record_done = 1'b0;
      end else begin
         next_index = cur + 1'b1;
      end
   endtask

   // Offer one sample beat, hold it until taken, then log what it should yield
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic is_last,
                              input bit typed, input result_type typed_r);
      bit         fires;
      result_type r;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= s;
      req_bus.last_sample <= is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_trigger(s, is_last, fires, r);
      if (typed) trigger_q.push_back(typed_r);
      else if (fires) trigger_q.push_back(r);
      sample_count++;
      if (is_last) record_count++;
   endtask

   // Drop valid, drain all owed results, then let the pipeline settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (trigger_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [POS_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TRIGGER_LEVEL: lvl_q    = data[SAMPLE_W-1:0];
         CSR_START_OFFSET:  offset_q = data;
         CSR_RECORD_LENGTH: length_q = data;
         CSR_SCREEN_WIDTH:  screen_q = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [SAMPLE_W-1:0] lvl, input logic [POS_W-1:0] off,
                               input logic [POS_W-1:0] len, input logic [POS_W-1:0] scr);
      wait_idle();
      csr_write(CSR_TRIGGER_LEVEL, {8'd0, lvl});
      csr_write(CSR_START_OFFSET, off);
      csr_write(CSR_RECORD_LENGTH, len);
      csr_write(CSR_SCREEN_WIDTH, scr);
      config_count++;
   endtask

   // Mostly small windows that a short record can reach; now and then the extremes
   task automatic random_config();
      logic [SAMPLE_W-1:0] lvl;
      logic [POS_W-1:0]    off;
      logic [POS_W-1:0]    len;
      logic [POS_W-1:0]    scr;
      case ($urandom_range(5))
         0:       lvl = 8'd0;
         1:       lvl = 8'd255;
         default: lvl = SAMPLE_W'($urandom_range(255));
      endcase
      case ($urandom_range(7))
         0:       scr = POS_W'($urandom_range(65535));
         1:       scr = 16'hFFFF;
         default: scr = POS_W'($urandom_range(40));
      endcase
      case ($urandom_range(9))
         0:       off = POS_W'($urandom_range(65535));
         1:       off = 16'hFFFF;
         default: off = POS_W'($urandom_range(6));
      endcase
      case ($urandom_range(9))
         0:       len = POS_W'($urandom_range(65535));
         1:       len = 16'd0;
         2:       len = 16'hFFFF;
         default: len = (scr >> 1) + POS_W'($urandom_range(40));
      endcase
      write_config(lvl, off, len, scr);
   endtask

   // One record: mostly runs that swing across the level, else noise or near-level
   task automatic send_record(input int n);
      int                  mode;
      int                  run;
      int                  v;
      bit                  low_side;
      logic [SAMPLE_W-1:0] s;
      mode     = $urandom_range(99);
      low_side = 1'($urandom_range(1));
      run      = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
         if (mode < 60) begin
            if (run == 0) begin
               low_side = !low_side;
               run      = $urandom_range(1, 3);
            end
            run--;
            if (low_side) s = SAMPLE_W'($urandom_range(lvl_q));
            else if (lvl_q == 8'd255) s = 8'd255;
            else s = SAMPLE_W'($urandom_range(255, lvl_q + 1));
         end else if (mode < 85) begin
            s = SAMPLE_W'($urandom_range(255));
         end else begin
            v = int'(lvl_q) + int'($urandom_range(2)) - 1;
            s = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[SAMPLE_W-1:0];
         end
         send_sample(s, k == n - 1, 1'b0, '0);
      end
   endtask

   function automatic dir_row_type row_sample(input logic [SAMPLE_W-1:0] s,
                                              input logic is_last);
      dir_row_type row;
      row         = '{kind: ROW_SAMPLE, reg_idx: CSR_TRIGGER_LEVEL, default: '0};
      row.kind    = ROW_SAMPLE;
      row.sample  = s;
      row.is_last = is_last;
      return row;
   endfunction

   function automatic dir_row_type row_result(input logic [SAMPLE_W-1:0] s,
                                              input logic is_last,
                                              input logic [POS_W-1:0] pos,
                                              input outcome_type oc);
      dir_row_type row;
      row                       = row_sample(s, is_last);
      row.typed                 = 1'b1;
      row.want.trigger_position = pos;
      row.want.outcome          = oc;
      return row;
   endfunction

   function automatic dir_row_type row_write(input csr_index_type idx,
                                             input logic [POS_W-1:0] data);
      dir_row_type row;
      row         = '{kind: ROW_WRITE, reg_idx: CSR_TRIGGER_LEVEL, default: '0};
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.wdata   = data;
      return row;
   endfunction

   // Result side: check each taken beat against the oldest owed result, then
   // decide whether to stall the next cycle
   initial begin
      result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (trigger_q.size() == 0) begin
               report_mismatch("result beat with none owed, position",
                               rsp_bus.trigger_position, 0);
            end else begin
               want = trigger_q.pop_front();
               result_count++;
               if (rsp_bus.trigger_position !== want.trigger_position)
                  report_mismatch("trigger_position", rsp_bus.trigger_position,
                                  want.trigger_position);
               if (rsp_bus.outcome !== want.outcome)
                  report_mismatch("outcome", rsp_bus.outcome, want.outcome);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int phase_start;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.sample      <= '0;
      req_bus.last_sample <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;

      // Directed records. At reset: level 128, half screen 240, limit 3856.
      // Full edge right after reset, result wraps below zero
      plan.push_back(row_sample(8'd200, 1'b0));
      plan.push_back(row_sample(8'd100, 1'b0));
      plan.push_back(row_sample(8'd200, 1'b0));
      plan.push_back(row_result(8'd128, 1'b0, 16'd65299, OUTCOME_FULL_EDGE));
      plan.push_back(row_sample(8'd0, 1'b1));
      // Single-sample record that never crosses: offset fallback
      plan.push_back(row_result(8'd255, 1'b1, 16'd0, OUTCOME_OFFSET));
      // Stays asserted, rise never comes: first crossing fallback
      plan.push_back(row_sample(8'd0, 1'b0));
      plan.push_back(row_sample(8'd0, 1'b0));
      plan.push_back(row_result(8'd0, 1'b1, 16'd65296, OUTCOME_FIRST_CROSS));
      // Level 0, offset 2, length and screen at their maximum: limit 32768
      plan.push_back(row_write(CSR_TRIGGER_LEVEL, 16'd0));
      plan.push_back(row_write(CSR_START_OFFSET, 16'd2));
      plan.push_back(row_write(CSR_RECORD_LENGTH, 16'hFFFF));
      plan.push_back(row_write(CSR_SCREEN_WIDTH, 16'hFFFF));
      plan.push_back(row_sample(8'd0, 1'b0));
      plan.push_back(row_sample(8'd255, 1'b0));
      plan.push_back(row_sample(8'd0, 1'b0));
      plan.push_back(row_sample(8'd1, 1'b0));
      plan.push_back(row_result(8'd0, 1'b0, 16'd32773, OUTCOME_FULL_EDGE));
      plan.push_back(row_sample(8'd255, 1'b1));
      // Empty window: offset beyond a zero limit
      plan.push_back(row_write(CSR_TRIGGER_LEVEL, 16'd255));
      plan.push_back(row_write(CSR_START_OFFSET, 16'hFFFF));
      plan.push_back(row_write(CSR_RECORD_LENGTH, 16'd0));
      plan.push_back(row_write(CSR_SCREEN_WIDTH, 16'd0));
      plan.push_back(row_sample(8'd0, 1'b0));
      plan.push_back(row_sample(8'd128, 1'b0));
      plan.push_back(row_result(8'd255, 1'b1, 16'hFFFF, OUTCOME_OFFSET));
      // Limit wraps to the top; everything asserted at level 255
      plan.push_back(row_write(CSR_START_OFFSET, 16'd0));
      plan.push_back(row_write(CSR_SCREEN_WIDTH, 16'd2));
      plan.push_back(row_sample(8'd255, 1'b0));
      plan.push_back(row_result(8'd255, 1'b1, 16'hFFFF, OUTCOME_FIRST_CROSS));
      // Odd screen width, full edge landing on the last sample
      plan.push_back(row_write(CSR_TRIGGER_LEVEL, 16'd128));
      plan.push_back(row_write(CSR_RECORD_LENGTH, 16'd4096));
      plan.push_back(row_write(CSR_SCREEN_WIDTH, 16'd481));
      plan.push_back(row_sample(8'd129, 1'b0));
      plan.push_back(row_sample(8'd127, 1'b0));
      plan.push_back(row_sample(8'd129, 1'b0));
      plan.push_back(row_sample(8'd127, 1'b1));

      // Hold reset, then release it once for good
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            wait_idle();
            csr_write(plan[i].reg_idx, plan[i].wdata);
            config_count++;
         end else begin
            send_sample(plan[i].sample, plan[i].is_last, plan[i].typed, plan[i].want);
         end
      end

      // Random records in four idle patterns: none, sender gaps, receiver
      // stalls, both.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct  = 37;
               recv_stall_pct = 37;
            end
         endcase
         phase_start = sample_count;
         random_config();
         while (sample_count - phase_start < 175) begin
            if ($urandom_range(5) == 0) random_config();
            send_record(($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 16));
         end
      end

      // Drain what is owed, let the pipeline settle, then decide
      wait_idle();
      repeat (4) @(posedge clock);
      $display("Covered %0d samples in %0d records under %0d register settings,",
               sample_count, record_count, config_count);
      $display("%0d trigger results checked across four idle patterns.",
               result_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hang: far longer than the slowest correct run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/stef_pkg.sv
hw/rtl/stef_req_if.sv
hw/rtl/stef_rsp_if.sv
hw/rtl/stef_csr.sv
hw/rtl/stef_search.sv
hw/rtl/stef_out_reg.sv
hw/rtl/scope_edge_trigger_finder.sv
hw/rtl/stef_checker.sv
tb/tb.sv
